// File: rtl/tcps_pkg.sv
`default_nettype none

package tcps_pkg;

   localparam int SLOTS      = 64;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int TICKET_MAX = 1023;
   // The ticket total plus one must fit, for the largest table as well.
   localparam int SUM_W      = $clog2(SLOTS * TICKET_MAX + 2);
   localparam int DIVD_W     = (2 * SUM_W > 32) ? 2 * SUM_W : 32;
   localparam int CNT_W      = $clog2(DIVD_W + 1);

   localparam logic [29:0] DRAW_OFFSET = 30'd1000000007;
   localparam logic [23:0] REM_MAX     = 24'hFFFFFF;

   typedef enum logic [2:0] {
      OP_SCHEDULE    = 3'd0,
      OP_ADMIT       = 3'd1,
      OP_SET_STATE   = 3'd2,
      OP_SET_CLASS   = 3'd3,
      OP_SET_TICKETS = 3'd4,
      OP_SET_PRIO    = 3'd5
   } op_type;

   localparam logic [2:0] TS_EMBRYO   = 3'd1;
   localparam logic [2:0] TS_RUNNABLE = 3'd3;
   localparam logic [2:0] TS_RUNNING  = 3'd4;
   localparam logic [2:0] TS_LAST     = 3'd5;

   localparam logic [1:0] CL_LOTTERY = 2'd0;
   localparam logic [1:0] CL_HRRN    = 2'd1;
   localparam logic [1:0] CL_SRPF    = 2'd2;
   localparam logic [1:0] CL_LAST    = 2'd3;

   localparam logic [1:0] CSR_DEFAULT_TICKETS = 2'd0;
   localparam logic [1:0] CSR_SRPF_CEILING    = 2'd1;
   localparam logic [1:0] CSR_SRPF_STEP       = 2'd2;

   typedef struct packed {
      logic [2:0]  state;
      logic [1:0]  cls;
      logic [9:0]  tickets;
      logic [31:0] arrival;
      logic [31:0] cycles;
      logic [23:0] remaining;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [SUM_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] rem;
   } mod_rsp_type;

endpackage

`default_nettype wire

// File: rtl/tcps_ram.sv
`default_nettype none

module tcps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/tcps_mod.sv
`default_nettype none

module tcps_mod
   import tcps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type req,
   output mod_rsp_type      rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] dvd_ff, dvd_in;
   logic [SUM_W-1:0]  dsr_ff, dsr_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W:0]    trial;

   // Restoring remainder: one dividend bit is brought down each cycle.
   always_comb begin
      trial   = {rem_ff, dvd_ff[DIVD_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVD_W);
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIVD_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SUM_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[SUM_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

`default_nettype wire

// File: rtl/three_class_process_scheduler_unit.sv
`default_nettype none

// Task scheduler over a table of SLOTS slots held in one RAM row per slot. Each request beat
// is either a write to one slot (read, modify, write, respond) or a schedule request, which
// walks the table with a small sequencer (read, evaluate, next for each slot) in passes: one
// pass sums lottery tickets, four passes of a shared bit-serial remainder unit form the draw,
// then up to three more walks serve lottery, HRRN (each HRRN candidate also steps through
// S_H_MUL1, S_H_MUL2 and S_H_CMP) and SRPF. One request is worked on at a time; a finished
// response may wait in its output register while the next request is taken.
module three_class_process_scheduler_unit
   import tcps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // operation[2:0], slot[8:3], value[32:9], decimals[34:33], now[66:35], zero fill
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // found[0], chosen_slot[6:1], chosen_class[8:7], zero fill
   output logic      [15:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_OP_RD, S_OP_WR, S_WALK_RD, S_WALK_EV, S_NEXT, S_H_MUL1, S_H_MUL2,
      S_H_CMP, S_MOD_GO, S_MOD_WAIT, S_MUL, S_DRAW_ADD, S_UPD_RD, S_UPD_WR, S_DONE
   } fsm_type;

   typedef enum logic [1:0] {PH_SUM, PH_LOT, PH_HRRN, PH_SRPF} phase_type;
   typedef enum logic [1:0] {DS_T, DS_SQ, DS_CUBE, DS_OFF} step_type;

   fsm_type   state_ff, state_in;
   phase_type phase_ff, phase_in;
   step_type  step_ff, step_in;

   logic [9:0]  dflt_tickets_ff, dflt_tickets_in;
   logic [23:0] ceiling_ff, ceiling_in;
   logic [9:0]  srpf_step_ff, srpf_step_in;
   logic [31:0] admitted_ff, admitted_in;

   logic [2:0]  op_ff, op_in;
   logic [5:0]  slot_ff, slot_in;
   logic [23:0] value_ff, value_in;
   logic [1:0]  dec_ff, dec_in;
   logic [31:0] now_ff, now_in;

   logic [SLOT_W:0]   idx_ff, idx_in;
   logic [SLOT_W:0]   idx_nx;
   logic [SLOT_W-1:0] pick_ff, pick_in;
   logic [1:0]        cls_ff, cls_in;
   logic              have_ff, have_in;
   logic              found_ff, found_in;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  t_ff, t_in;
   logic [SUM_W-1:0]  r_ff, r_in;
   logic [DIVD_W-1:0] prod_ff, prod_in;
   logic [SUM_W:0]    draw_sum;

   logic signed [31:0] w_ff, w_in;
   logic [31:0]        c_ff, c_in;
   logic signed [31:0] best_w_ff, best_w_in;
   logic [31:0]        best_c_ff, best_c_in;
   logic signed [65:0] pa_ff, pa_in;
   logic signed [65:0] pb_ff, pb_in;
   logic [23:0]        best_rem_ff, best_rem_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]       rsp_tdata_ff, rsp_tdata_in;

   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic              rd_valid_ff;
   logic [SLOT_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   row_type           wr_row, ram_row, row;
   logic              in_range;
   logic [30:0]       prio_wide;
   logic [31:0]       wait_d;

   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   tcps_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (ram_row)
   );

   tcps_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   // A slot never written reads as unused.
   always_comb begin
      row = ram_row;
      if (!rd_valid_ff) begin
         row.state = '0;
      end
   end

   always_comb begin
      case (state_ff)
         S_OP_RD:  rd_addr = SLOT_W'(slot_ff);
         S_UPD_RD: rd_addr = pick_ff;
         default:  rd_addr = idx_ff[SLOT_W-1:0];
      endcase
   end

   assign in_range = 32'(slot_ff) < 32'(SLOTS);
   assign idx_nx   = idx_ff + 1'b1;
   assign wait_d   = now_ff - row.arrival;
   assign draw_sum = {1'b0, r_ff} + {1'b0, t_ff};

   always_comb begin
      case (dec_ff)
         2'd0:    prio_wide = 31'(value_ff) * 31'd100;
         2'd1:    prio_wide = 31'(value_ff) * 31'd10;
         default: prio_wide = 31'(value_ff);
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      step_in         = step_ff;
      dflt_tickets_in = dflt_tickets_ff;
      ceiling_in      = ceiling_ff;
      srpf_step_in    = srpf_step_ff;
      admitted_in     = admitted_ff;
      op_in           = op_ff;
      slot_in         = slot_ff;
      value_in        = value_ff;
      dec_in          = dec_ff;
      now_in          = now_ff;
      idx_in          = idx_ff;
      pick_in         = pick_ff;
      cls_in          = cls_ff;
      have_in         = have_ff;
      found_in        = found_ff;
      sum_in          = sum_ff;
      t_in            = t_ff;
      r_in            = r_ff;
      prod_in         = prod_ff;
      w_in            = w_ff;
      c_in            = c_ff;
      best_w_in       = best_w_ff;
      best_c_in       = best_c_ff;
      pa_in           = pa_ff;
      pb_in           = pb_ff;
      best_rem_in     = best_rem_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in    = rsp_tdata_ff;
      valid_in        = valid_ff;
      wr_en           = 1'b0;
      wr_addr         = SLOT_W'(slot_ff);
      wr_row          = row;
      mod_req.start    = 1'b0;
      mod_req.divisor  = sum_ff;
      mod_req.dividend = DIVD_W'(now_ff);

      if (csr_we) begin
         case (csr_index)
            CSR_DEFAULT_TICKETS: dflt_tickets_in = csr_wdata[9:0];
            CSR_SRPF_CEILING:    ceiling_in      = csr_wdata;
            CSR_SRPF_STEP:       srpf_step_in    = csr_wdata[9:0];
            default:             ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[2:0];
               slot_in  = req_tdata[8:3];
               value_in = req_tdata[32:9];
               dec_in   = req_tdata[34:33];
               now_in   = req_tdata[66:35];
               if (req_tdata[2:0] == OP_SCHEDULE) begin
                  phase_in = PH_SUM;
                  sum_in   = SUM_W'(1);
                  idx_in   = '0;
                  state_in = S_WALK_RD;
               end else begin
                  state_in = S_OP_RD;
               end
            end
         end

         S_OP_RD: state_in = S_OP_WR;

         S_OP_WR: begin
            found_in = 1'b0;
            pick_in  = '0;
            cls_in   = CL_LOTTERY;
            state_in = S_DONE;
            if (in_range) begin
               case (op_ff)
                  OP_ADMIT: begin
                     wr_en          = 1'b1;
                     wr_row.state   = TS_EMBRYO;
                     wr_row.cls     = CL_LOTTERY;
                     wr_row.tickets = dflt_tickets_ff;
                     wr_row.arrival = now_ff + admitted_ff;
                     wr_row.cycles  = 32'd1;
                     admitted_in    = admitted_ff + 1'b1;
                  end
                  OP_SET_STATE: begin
                     wr_en = 1'b1;
                     if (value_ff <= 24'(TS_LAST)) begin
                        wr_row.state = value_ff[2:0];
                     end
                  end
                  OP_SET_CLASS: begin
                     wr_en = 1'b1;
                     if (value_ff <= 24'(CL_LAST)) begin
                        wr_row.cls = value_ff[1:0];
                     end
                  end
                  OP_SET_TICKETS: begin
                     wr_en = 1'b1;
                     wr_row.tickets = (value_ff > 24'(TICKET_MAX)) ? 10'(TICKET_MAX)
                                                                    : value_ff[9:0];
                  end
                  OP_SET_PRIO: begin
                     wr_en = 1'b1;
                     wr_row.remaining = (prio_wide > 31'(REM_MAX)) ? REM_MAX
                                                                   : prio_wide[23:0];
                  end
                  default: ;
               endcase
               if (wr_en) begin
                  valid_in[SLOT_W'(slot_ff)] = 1'b1;
               end
            end
         end

         S_WALK_RD: state_in = S_WALK_EV;

         S_WALK_EV: begin
            state_in = S_NEXT;
            case (phase_ff)
               PH_SUM: begin
                  if (row.state == TS_RUNNABLE && row.cls == CL_LOTTERY) begin
                     sum_in = sum_ff + SUM_W'(row.tickets);
                  end
               end
               PH_LOT: begin
                  if (row.state == TS_RUNNABLE && row.cls == CL_LOTTERY) begin
                     if (SUM_W'(row.tickets) >= r_ff) begin
                        pick_in  = idx_ff[SLOT_W-1:0];
                        cls_in   = CL_LOTTERY;
                        state_in = S_UPD_RD;
                     end else begin
                        r_in = r_ff - SUM_W'(row.tickets);
                     end
                  end
               end
               PH_HRRN: begin
                  if (row.state == TS_RUNNABLE && row.cls == CL_HRRN) begin
                     w_in     = $signed(wait_d);
                     c_in     = (row.cycles == '0) ? 32'd1 : row.cycles;
                     state_in = S_H_MUL1;
                  end
               end
               default: begin
                  if (row.state == TS_RUNNABLE && row.cls == CL_SRPF
                      && row.remaining < best_rem_ff) begin
                     best_rem_in = row.remaining;
                     pick_in     = idx_ff[SLOT_W-1:0];
                     have_in     = 1'b1;
                  end
               end
            endcase
         end

         S_H_MUL1: begin
            pa_in    = $signed({w_ff[31], w_ff}) * $signed({1'b0, best_c_ff});
            state_in = S_H_MUL2;
         end

         S_H_MUL2: begin
            pb_in    = $signed({best_w_ff[31], best_w_ff}) * $signed({1'b0, c_ff});
            state_in = S_H_CMP;
         end

         S_H_CMP: begin
            if (pa_ff > pb_ff) begin
               best_w_in = w_ff;
               best_c_in = c_ff;
               pick_in   = idx_ff[SLOT_W-1:0];
               have_in   = 1'b1;
            end
            state_in = S_NEXT;
         end

         S_NEXT: begin
            if (idx_nx == (SLOT_W + 1)'(SLOTS)) begin
               idx_in = '0;
               case (phase_ff)
                  PH_SUM: begin
                     if (sum_ff == SUM_W'(1)) begin
                        phase_in  = PH_HRRN;
                        best_w_in = -32'sd1;
                        best_c_in = 32'd1;
                        have_in   = 1'b0;
                        state_in  = S_WALK_RD;
                     end else begin
                        step_in  = DS_T;
                        state_in = S_MOD_GO;
                     end
                  end
                  PH_LOT: begin
                     phase_in  = PH_HRRN;
                     best_w_in = -32'sd1;
                     best_c_in = 32'd1;
                     have_in   = 1'b0;
                     state_in  = S_WALK_RD;
                  end
                  PH_HRRN: begin
                     if (have_ff) begin
                        cls_in   = CL_HRRN;
                        state_in = S_UPD_RD;
                     end else begin
                        phase_in    = PH_SRPF;
                        best_rem_in = ceiling_ff;
                        state_in    = S_WALK_RD;
                     end
                  end
                  default: begin
                     if (have_ff) begin
                        cls_in   = CL_SRPF;
                        state_in = S_UPD_RD;
                     end else begin
                        found_in = 1'b0;
                        pick_in  = '0;
                        cls_in   = CL_LOTTERY;
                        state_in = S_DONE;
                     end
                  end
               endcase
            end else begin
               idx_in   = idx_nx;
               state_in = S_WALK_RD;
            end
         end

         S_MOD_GO: begin
            mod_req.start = 1'b1;
            case (step_ff)
               DS_T:    mod_req.dividend = DIVD_W'(now_ff);
               DS_OFF:  mod_req.dividend = DIVD_W'(DRAW_OFFSET);
               default: mod_req.dividend = prod_ff;
            endcase
            state_in = S_MOD_WAIT;
         end

         S_MOD_WAIT: begin
            if (mod_rsp.done) begin
               case (step_ff)
                  DS_T: begin
                     t_in     = mod_rsp.rem;
                     step_in  = DS_SQ;
                     state_in = S_MUL;
                  end
                  DS_SQ: begin
                     r_in     = mod_rsp.rem;
                     step_in  = DS_CUBE;
                     state_in = S_MUL;
                  end
                  DS_CUBE: begin
                     r_in     = mod_rsp.rem;
                     step_in  = DS_OFF;
                     state_in = S_MOD_GO;
                  end
                  default: begin
                     // The tick value is no longer needed, so t holds the offset.
                     t_in     = mod_rsp.rem;
                     state_in = S_DRAW_ADD;
                  end
               endcase
            end
         end

         S_MUL: begin
            prod_in  = DIVD_W'(t_ff) * DIVD_W'((step_ff == DS_SQ) ? t_ff : r_ff);
            state_in = S_MOD_GO;
         end

         S_DRAW_ADD: begin
            if (draw_sum >= {1'b0, sum_ff}) begin
               r_in = SUM_W'(draw_sum - {1'b0, sum_ff});
            end else begin
               r_in = draw_sum[SUM_W-1:0];
            end
            phase_in = PH_LOT;
            idx_in   = '0;
            state_in = S_WALK_RD;
         end

         S_UPD_RD: state_in = S_UPD_WR;

         S_UPD_WR: begin
            wr_en        = 1'b1;
            wr_addr      = pick_ff;
            wr_row.state = TS_RUNNING;
            if (row.cycles != '1) begin
               wr_row.cycles = row.cycles + 1'b1;
            end
            if (cls_ff == CL_SRPF && row.remaining >= 24'(srpf_step_ff)) begin
               wr_row.remaining = row.remaining - 24'(srpf_step_ff);
            end
            valid_in[pick_ff] = 1'b1;
            found_in = 1'b1;
            state_in = S_DONE;
         end

         default: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'd0, cls_ff, 6'(pick_ff), found_ff};
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= PH_SUM;
         step_ff         <= DS_T;
         dflt_tickets_ff <= 10'd50;
         ceiling_ff      <= 24'd10000000;
         srpf_step_ff    <= 10'd10;
         admitted_ff     <= '0;
         rsp_tvalid_ff   <= 1'b0;
         valid_ff        <= '0;
         have_ff         <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         step_ff         <= step_in;
         dflt_tickets_ff <= dflt_tickets_in;
         ceiling_ff      <= ceiling_in;
         srpf_step_ff    <= srpf_step_in;
         admitted_ff     <= admitted_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
         valid_ff        <= valid_in;
         have_ff         <= have_in;
      end
      rd_valid_ff  <= valid_ff[rd_addr];
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      value_ff     <= value_in;
      dec_ff       <= dec_in;
      now_ff       <= now_in;
      idx_ff       <= idx_in;
      pick_ff      <= pick_in;
      cls_ff       <= cls_in;
      found_ff     <= found_in;
      sum_ff       <= sum_in;
      t_ff         <= t_in;
      r_ff         <= r_in;
      prod_ff      <= prod_in;
      w_ff         <= w_in;
      c_ff         <= c_in;
      best_w_ff    <= best_w_in;
      best_c_ff    <= best_c_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      best_rem_ff  <= best_rem_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_nofind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'd0)
      else $error("response without a pick carries a slot or class");

   a_class_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:7] != CL_LAST)
      else $error("response names a class that cannot pick");

   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> mod_rsp.rem < sum_ff)
      else $error("remainder not below the ticket total");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in progress");

endmodule

`default_nettype wire
